// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants for the byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

	// field widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ADDR_W    = 64;
	localparam int unsigned PATTERN_W = 64;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned LIMIT_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	// register reset values
	localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = '1;

	typedef logic [BYTE_W-1:0] byte_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_RESULT_LIMIT   = 2'd2
	} cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/bps_window.sv =====
// ----------------------------------------------------------------------------
// bps_window
// Compares the byte window against the pattern for every possible length
// and picks the result for the configured length.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_window #(
	parameter int unsigned MAX_PATTERN_BYTES = 8
) (
	input  bps_pkg::byte_t                    win [MAX_PATTERN_BYTES],
	input  logic [bps_pkg::PATTERN_W-1:0]     pattern,
	input  logic [bps_pkg::LEN_W-1:0]         length,
	output logic                              hit
);
	import bps_pkg::*;

	logic [MAX_PATTERN_BYTES-1:0] match_l;

	// one full compare per candidate length; window entry 0 is the newest byte
	always_comb begin
		for (int l = 0; l < MAX_PATTERN_BYTES; l++) begin
			match_l[l] = 1'b1;
			for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
				if (i <= l) begin
					if (win[l-i] != pattern[BYTE_W*i +: BYTE_W]) begin
						match_l[l] = 1'b0;
					end
				end
			end
		end
	end

	// select by configured length
	always_comb begin
		hit = 1'b0;
		for (int l = 0; l < MAX_PATTERN_BYTES; l++) begin
			if (length == LEN_W'(l + 1)) begin
				hit = match_l[l];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// byte_pattern_scanner
// Exact byte pattern search over a stream of memory bytes, reporting the
// start address of every match until a configured number of matches.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  input    | in_valid / in_ready   | data_byte, byte_address, run_start,
//           |                       | scan_start
//  output   | out_valid / out_ready | match_address, limit_reached
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
//  One item per clock sustained while results are not stalled. An item is
//  held in the input register, then the window compare, count update and
//  address subtract produce its result into the output register.
//  A stalled result holds the output register; the input register keeps
//  taking an item until it too is full. Reset clears all control state and
//  sets the registers to their reset values; no clearing pass is needed.
//
`default_nettype none

module byte_pattern_scanner #(
	parameter int unsigned MAX_PATTERN_BYTES = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bps_pkg::byte_t                    data_byte,
	input  logic [bps_pkg::ADDR_W-1:0]        byte_address,
	input  logic                              run_start,
	input  logic                              scan_start,
	// result items
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [bps_pkg::ADDR_W-1:0]        match_address,
	output logic                              limit_reached,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bps_pkg::PATTERN_W-1:0]     cfg_data
);
	import bps_pkg::*;

	localparam int unsigned FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

	// configuration registers
	logic [PATTERN_W-1:0] pattern_q;
	logic [LEN_W-1:0]     length_q;
	logic [LIMIT_W-1:0]   limit_q;

	// scan state
	byte_t               hist_q [MAX_PATTERN_BYTES];
	logic [FILL_W-1:0]   fill_q;
	logic [LIMIT_W-1:0]  count_q;
	logic                stop_q;

	// input register
	logic                v_s1;
	byte_t               byte_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                run_s1;
	logic                scan_s1;

	// result register
	logic                out_valid_q;
	logic [ADDR_W-1:0]   match_address_q;
	logic                limit_reached_q;

	// datapath
	logic                adv;
	logic                stop_eff;
	logic                run_eff;
	byte_t               hist_shift [MAX_PATTERN_BYTES];
	logic [FILL_W-1:0]   fill_base;
	logic [FILL_W-1:0]   fill_next;
	logic                len_ok;
	logic                fill_ok;
	logic                win_hit;
	logic                hit;
	logic [LIMIT_W-1:0]  count_next;
	logic                at_limit;

	assign cfg_ready     = 1'b1;
	assign adv           = v_s1 && (!out_valid_q || out_ready);
	assign in_ready      = !v_s1 || adv;
	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;
	assign limit_reached = limit_reached_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			length_q  <= LEN_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_PATTERN_BYTES:  pattern_q <= cfg_data;
				CFG_PATTERN_LENGTH: length_q  <= cfg_data[LEN_W-1:0];
				CFG_RESULT_LIMIT:   limit_q   <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			addr_s1 <= byte_address;
			run_s1  <= run_start;
			scan_s1 <= scan_start;
		end
	end

	// shifted history with the new byte in front
	always_comb begin
		hist_shift[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			hist_shift[k] = hist_q[k-1];
		end
	end

	// fill count, limits and match decision
	always_comb begin
		stop_eff   = stop_q && !scan_s1;
		run_eff    = run_s1 || scan_s1;
		fill_base  = run_eff ? '0 : fill_q;
		fill_next  = (fill_base == FILL_W'(MAX_PATTERN_BYTES)) ?
			FILL_W'(MAX_PATTERN_BYTES) : fill_base + FILL_W'(1);
		len_ok     = (length_q != '0) && (length_q <= LEN_W'(MAX_PATTERN_BYTES));
		fill_ok    = LEN_W'(fill_next) >= length_q;
		hit        = !stop_eff && len_ok && (limit_q != '0) && fill_ok && win_hit;
		count_next = (scan_s1 ? '0 : count_q) + LIMIT_W'(1);
		at_limit   = count_next >= limit_q;
	end

	bps_window #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
	) u_window (
		.win     (hist_shift),
		.pattern (pattern_q),
		.length  (length_q),
		.hit     (win_hit)
	);

	// scan state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			stop_q  <= 1'b0;
		end else if (adv) begin
			if (hit) begin
				count_q <= count_next;
			end else if (scan_s1) begin
				count_q <= '0;
			end
			if (hit && at_limit) begin
				stop_q <= 1'b1;
			end else if (scan_s1) begin
				stop_q <= 1'b0;
			end
			if (stop_eff) begin
				if (run_eff) begin
					fill_q <= '0;
				end
			end else begin
				fill_q <= fill_next;
			end
		end
	end

	// history bytes, read only below the fill count
	always_ff @(posedge clk) begin
		if (adv && !stop_eff) begin
			hist_q <= hist_shift;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit) begin
			match_address_q <= addr_s1 - (ADDR_W'(length_q) - ADDR_W'(1));
			limit_reached_q <= at_limit;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bps_checker.sv =====
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks for the byte pattern scanner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [bps_pkg::ADDR_W-1:0]        match_address,
	input  logic                              limit_reached,
	input  logic                              cfg_ready
);
	import bps_pkg::*;

	// a stalled result item holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_address)
			&& $stable(limit_reached))
		else $error("result item changed while stalled");

	// with the output register empty the input side never stalls
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output register");

	// an item taken behind a stalled result fills the input stage, which then
	// frees up only as the result leaves
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && in_valid && in_ready |=> in_ready == out_ready)
		else $error("input taken beyond buffer depth");

	// configuration writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind byte_pattern_scanner bps_checker u_bps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.match_address (match_address),
	.limit_reached (limit_reached),
	.cfg_ready     (cfg_ready)
);

`default_nettype wire
